>>> hw/rtl/mbsf_pkg.sv
package mbsf_pkg;

  localparam int BYTE_W     = 8;
  localparam int SEQ_BYTES  = 4;
  localparam int SEQ_W      = SEQ_BYTES * BYTE_W;
  localparam int LEN_W      = 3;
  localparam int PEND_DEPTH = SEQ_BYTES - 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = SEQ_W;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = 2;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_END   = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_DELIM = 3'd0,
    REG_START_LEN   = 3'd1,
    REG_END_DELIM   = 3'd2,
    REG_END_LEN     = 3'd3,
    REG_STUFF_SEQ   = 3'd4,
    REG_STUFF_LEN   = 3'd5,
    REG_ESCAPE_SEQ  = 3'd6,
    REG_ESCAPE_LEN  = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    JOB_START  = 2'd0,
    JOB_DECIDE = 2'd1,
    JOB_END    = 2'd2
  } job_kind_t;

  typedef enum logic [2:0] {
    PH_MATCH0 = 3'd0,
    PH_MATCH1 = 3'd1,
    PH_MATCH2 = 3'd2,
    PH_BYTE   = 3'd3,
    PH_DELIM  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [SEQ_W-1:0] start_delim;
    logic [LEN_W-1:0] start_len;
    logic [SEQ_W-1:0] end_delim;
    logic [LEN_W-1:0] end_len;
    logic [SEQ_W-1:0] stuff_seq;
    logic [LEN_W-1:0] stuff_len;
    logic [SEQ_W-1:0] escape_seq;
    logic [LEN_W-1:0] escape_len;
  } cfg_t;

  // count: window bytes still to decide (0 for a start job, 4 for a payload decision)
  typedef struct packed {
    job_kind_t                       kind;
    logic [LEN_W-1:0]                count;
    logic [SEQ_BYTES-1:0][BYTE_W-1:0] win;
  } job_t;

  localparam logic [SEQ_W-1:0] START_DELIM_RST = 32'h0000_007E;
  localparam logic [SEQ_W-1:0] END_DELIM_RST   = 32'h0000_007E;
  localparam logic [SEQ_W-1:0] STUFF_SEQ_RST   = 32'h0000_007D;
  localparam logic [SEQ_W-1:0] ESCAPE_SEQ_RST  = 32'h0063_7365;
  localparam logic [LEN_W-1:0] START_LEN_RST   = 3'd1;
  localparam logic [LEN_W-1:0] END_LEN_RST     = 3'd1;
  localparam logic [LEN_W-1:0] STUFF_LEN_RST   = 3'd1;
  localparam logic [LEN_W-1:0] ESCAPE_LEN_RST  = 3'd3;

  // Clamped length minus one: zero counts as one, above four counts as four.
  function automatic logic [1:0] len_m1(logic [LEN_W-1:0] v);
    logic [1:0] r;
    if (v == 3'd0) begin
      r = 2'd0;
    end else if (v > 3'd4) begin
      r = 2'd3;
    end else begin
      r = 2'(v - 3'd1);
    end
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] seq_byte(logic [SEQ_W-1:0] seq, logic [1:0] i);
    return seq[{i, 3'b000} +: BYTE_W];
  endfunction

endpackage

>>> hw/rtl/mbsf_if.sv
interface mbsf_item_if import mbsf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [BYTE_W-1:0] payload_byte;

  modport source (output valid, output cmd, output payload_byte, input ready);
  modport sink   (input valid, input cmd, input payload_byte, output ready);
endinterface

interface mbsf_stream_if import mbsf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

>>> hw/rtl/multi_byte_stuffing_framer_unit.sv
// Byte-stuffing framer with configurable multi-byte delimiters.
// item channel: cmd (start, payload byte, end) and payload_byte, valid/ready.
// stream channel: one framed byte per transfer in out_byte; run_last marks the
// last byte caused by an item. Start and end items always produce bytes; a
// payload item produces bytes only once three earlier bytes are pending.
// Configuration: cfg_we, cfg_index and cfg_data write one register per cycle.
// With the queue empty, the first byte of an item passes through the job
// queue and the registered output stage. Throughput: one output byte per
// cycle while stream.ready is high; an item produces 1 to 43 bytes, or none
// for a payload item without output. A four-entry job queue sits between
// the classifying front end and the byte generator; item.ready drops only
// while that queue is full. A stalled stream holds its byte; the front keeps
// taking items until the queue fills. Reset empties the queue and pending
// window, drops stream.valid and loads the default delimiters (0x7E), stuff
// byte (0x7D) and "esc".
module multi_byte_stuffing_framer_unit import mbsf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  mbsf_item_if.sink             item,
  mbsf_stream_if.source         stream,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  job_t job_in;
  job_t job_head;
  logic push;
  logic pop;
  logic full;
  logic empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_delim <= START_DELIM_RST;
      cfg.start_len   <= START_LEN_RST;
      cfg.end_delim   <= END_DELIM_RST;
      cfg.end_len     <= END_LEN_RST;
      cfg.stuff_seq   <= STUFF_SEQ_RST;
      cfg.stuff_len   <= STUFF_LEN_RST;
      cfg.escape_seq  <= ESCAPE_SEQ_RST;
      cfg.escape_len  <= ESCAPE_LEN_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_START_DELIM: cfg.start_delim <= cfg_data;
        REG_START_LEN:   cfg.start_len   <= cfg_data[LEN_W-1:0];
        REG_END_DELIM:   cfg.end_delim   <= cfg_data;
        REG_END_LEN:     cfg.end_len     <= cfg_data[LEN_W-1:0];
        REG_STUFF_SEQ:   cfg.stuff_seq   <= cfg_data;
        REG_STUFF_LEN:   cfg.stuff_len   <= cfg_data[LEN_W-1:0];
        REG_ESCAPE_SEQ:  cfg.escape_seq  <= cfg_data;
        REG_ESCAPE_LEN:  cfg.escape_len  <= cfg_data[LEN_W-1:0];
        default:         cfg.escape_len  <= cfg.escape_len;
      endcase
    end
  end

  mbsf_front u_front (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .full (full),
    .push (push),
    .job  (job_in)
  );

  mbsf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .job_in  (job_in),
    .full    (full),
    .pop     (pop),
    .job_out (job_head),
    .empty   (empty)
  );

  mbsf_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .head   (job_head),
    .empty  (empty),
    .pop    (pop),
    .stream (stream)
  );

endmodule

>>> hw/rtl/mbsf_front.sv
module mbsf_front import mbsf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  mbsf_item_if.sink  item,
  input  logic       full,
  output logic       push,
  output job_t       job
);

  logic [PEND_DEPTH-1:0][BYTE_W-1:0] pend;
  logic [1:0]                        pend_cnt;
  logic                              accept;
  cmd_t                              cmd;

  assign item.ready = !full;
  assign accept     = item.valid && item.ready;
  assign cmd        = cmd_t'(item.cmd);

  always_comb begin
    push      = 1'b0;
    job.kind  = JOB_START;
    job.count = 3'd0;
    job.win   = {8'h00, pend[2], pend[1], pend[0]};
    case (cmd)
      CMD_START: begin
        push = accept;
      end
      CMD_BYTE: begin
        // window full: decide the oldest byte
        if (pend_cnt == 2'd3) begin
          push      = accept;
          job.kind  = JOB_DECIDE;
          job.count = 3'd4;
          job.win   = {item.payload_byte, pend[2], pend[1], pend[0]};
        end
      end
      CMD_END: begin
        push      = accept;
        job.kind  = JOB_END;
        job.count = {1'b0, pend_cnt};
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= '0;
      pend_cnt <= 2'd0;
    end else if (accept) begin
      case (cmd)
        CMD_START, CMD_END: begin
          pend_cnt <= 2'd0;
        end
        CMD_BYTE: begin
          if (pend_cnt == 2'd3) begin
            pend <= {item.payload_byte, pend[2], pend[1]};
          end else begin
            pend[pend_cnt] <= item.payload_byte;
            pend_cnt       <= pend_cnt + 2'd1;
          end
        end
        default: begin
          pend_cnt <= pend_cnt;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/mbsf_queue.sv
module mbsf_queue import mbsf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t job_in,
  output logic full,
  input  logic pop,
  output job_t job_out,
  output logic empty
);

  job_t            entries [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == (Q_AW + 1)'(Q_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign job_out = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hw/rtl/mbsf_back.sv
module mbsf_back import mbsf_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  job_t          head,
  input  logic          empty,
  output logic          pop,
  mbsf_stream_if.source stream
);

  logic [1:0]        pos;
  logic [1:0]        pos_next;
  logic [1:0]        idx;
  logic [1:0]        idx_next;
  phase_t            ph;
  phase_t            ph_next;
  phase_t            eff;
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              run_last;
  logic              advance;
  logic              last;
  logic [BYTE_W-1:0] byte_sel;
  logic [SEQ_BYTES-1:0][BYTE_W-1:0] sw;
  logic [LEN_W-1:0]  avail;
  logic [2:0]        hit;
  logic [1:0]        sl_m1;
  logic [1:0]        dl_m1;
  logic [SEQ_W-1:0]  dseq;

  function automatic logic pat_match(logic [SEQ_BYTES-1:0][BYTE_W-1:0] w,
                                     logic [LEN_W-1:0] n, logic [SEQ_W-1:0] seq,
                                     logic [1:0] lm1);
    logic ok;
    ok = ({1'b0, lm1} < n);
    for (int i = 0; i < SEQ_BYTES; i++) begin
      if (2'(i) <= lm1 && w[i] != seq_byte(seq, 2'(i))) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // window seen from the byte under decision
  always_comb begin
    for (int i = 0; i < SEQ_BYTES; i++) begin
      if (({1'b0, pos} + 3'(i)) > 3'd3) begin
        sw[i] = '0;
      end else begin
        sw[i] = head.win[2'(pos + 2'(i))];
      end
    end
  end

  assign avail  = head.count - {1'b0, pos};
  assign hit[0] = pat_match(sw, avail, cfg.start_delim, len_m1(cfg.start_len));
  assign hit[1] = pat_match(sw, avail, cfg.end_delim, len_m1(cfg.end_len));
  assign hit[2] = pat_match(sw, avail, cfg.escape_seq, len_m1(cfg.escape_len));
  assign sl_m1  = len_m1(cfg.stuff_len);
  assign dseq   = (head.kind == JOB_START) ? cfg.start_delim : cfg.end_delim;
  assign dl_m1  = (head.kind == JOB_START) ? len_m1(cfg.start_len) : len_m1(cfg.end_len);

  assign advance = !empty && (!out_valid || stream.ready);
  assign pop     = advance && last;

  always_comb begin
    // skip patterns that do not begin here
    eff = ph;
    if (head.count == 3'd0) begin
      eff = PH_DELIM;
    end else begin
      if (eff == PH_MATCH0 && !hit[0]) eff = PH_MATCH1;
      if (eff == PH_MATCH1 && !hit[1]) eff = PH_MATCH2;
      if (eff == PH_MATCH2 && !hit[2]) eff = PH_BYTE;
    end

    last     = 1'b0;
    byte_sel = '0;
    pos_next = pos;
    idx_next = idx;
    ph_next  = eff;
    case (eff)
      PH_MATCH0, PH_MATCH1, PH_MATCH2: begin
        byte_sel = seq_byte(cfg.stuff_seq, idx);
        if (idx == sl_m1) begin
          idx_next = 2'd0;
          case (eff)
            PH_MATCH0: ph_next = PH_MATCH1;
            PH_MATCH1: ph_next = PH_MATCH2;
            default:   ph_next = PH_BYTE;
          endcase
        end else begin
          idx_next = idx + 2'd1;
        end
      end
      PH_BYTE: begin
        byte_sel = sw[0];
        if (head.kind == JOB_DECIDE) begin
          last = 1'b1;
        end else if (({1'b0, pos} + 3'd1) == head.count) begin
          ph_next  = PH_DELIM;
          idx_next = 2'd0;
        end else begin
          pos_next = pos + 2'd1;
          ph_next  = PH_MATCH0;
        end
      end
      PH_DELIM: begin
        byte_sel = seq_byte(dseq, idx);
        if (idx == dl_m1) begin
          last = 1'b1;
        end else begin
          idx_next = idx + 2'd1;
        end
      end
      default: begin
        ph_next = PH_MATCH0;
      end
    endcase

    if (last) begin
      pos_next = 2'd0;
      idx_next = 2'd0;
      ph_next  = PH_MATCH0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= 2'd0;
      idx       <= 2'd0;
      ph        <= PH_MATCH0;
      out_valid <= 1'b0;
    end else if (advance) begin
      pos       <= pos_next;
      idx       <= idx_next;
      ph        <= ph_next;
      out_valid <= 1'b1;
    end else if (stream.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte <= byte_sel;
      run_last <= last;
    end
  end

  assign stream.valid    = out_valid;
  assign stream.out_byte = out_byte;
  assign stream.run_last = run_last;

endmodule

>>> hw/rtl/mbsf_checker.sv
module mbsf_checker import mbsf_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input logic [1:0]        item_cmd,
  input logic              stream_valid,
  input logic              stream_ready,
  input logic [BYTE_W-1:0] stream_out_byte,
  input logic              stream_run_last
);

  logic [1:0] pend_cnt;
  logic [3:0] open_jobs;
  logic       item_xfer;
  logic       new_job;
  logic       done_job;

  assign item_xfer = item_valid && item_ready;
  assign new_job   = item_xfer && (item_cmd == CMD_START || item_cmd == CMD_END ||
                     (item_cmd == CMD_BYTE && pend_cnt == 2'd3));
  assign done_job  = stream_valid && stream_ready && stream_run_last;

  // track items that owe output bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_cnt  <= 2'd0;
      open_jobs <= 4'd0;
    end else begin
      if (item_xfer) begin
        if (item_cmd == CMD_START || item_cmd == CMD_END) begin
          pend_cnt <= 2'd0;
        end else if (item_cmd == CMD_BYTE && pend_cnt != 2'd3) begin
          pend_cnt <= pend_cnt + 2'd1;
        end
      end
      open_jobs <= open_jobs + {3'd0, new_job} - {3'd0, done_job};
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !stream_valid)
    else $error("stream valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    stream_valid && !stream_ready |=>
      stream_valid && $stable(stream_out_byte) && $stable(stream_run_last))
    else $error("stalled stream byte changed");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    stream_valid |-> open_jobs != 4'd0)
    else $error("stream byte with no item owing output");

  a_ready_when_idle: assert property (@(posedge clk) disable iff (rst)
    open_jobs == 4'd0 |-> item_ready)
    else $error("item channel stalled with nothing in flight");

endmodule

bind multi_byte_stuffing_framer_unit mbsf_checker u_mbsf_checker (
  .clk             (clk),
  .rst             (rst),
  .item_valid      (item.valid),
  .item_ready      (item.ready),
  .item_cmd        (item.cmd),
  .stream_valid    (stream.valid),
  .stream_ready    (stream.ready),
  .stream_out_byte (stream.out_byte),
  .stream_run_last (stream.run_last)
);
